// File: design/irt_pkg.sv
// Shared types and codes for the interval reservation table.
// Used by the controller, the datapath and the top level; depends on nothing.

package irt_pkg;

  // Width of the time fields as they appear on the input channel.
  localparam int TIME_IN_W = 32;

  // Width of the entries_used result field.
  localparam int ENTRIES_W = 7;

  // Result codes carried in the status field.
  typedef enum logic [1:0] {
    ST_BOOKED  = 2'd0,
    ST_OVERLAP = 2'd1,
    ST_FULL    = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  // One request item.
  typedef struct packed {
    logic [TIME_IN_W-1:0] start_time;
    logic [TIME_IN_W-1:0] end_time;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic                 booked;
    status_e              status;
    logic [ENTRIES_W-1:0] entries_used;
  } out_item_t;

  // Controller states.
  typedef enum logic [1:0] {
    CS_IDLE,
    CS_SCAN,
    CS_FINISH
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture a new request and restart the scan
    logic scan;    // step the table scan
    logic commit;  // decide, store if booked, and load the result register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;      // scan finished or decided early
    logic out_busy;  // result register holds an item that is stalled
  } dp_sts_t;

endpackage

// File: design/interval_reservation_table.sv
// Interval reservation table, top level.
// Joins the controller and the datapath; uses irt_pkg.
//
// Usage:
// The input channel carries one request item, the half-open interval
// [start_time, end_time). The output channel returns one result item per
// request: booked, status (booked, overlap, table full, invalid interval)
// and the number of stored intervals after the request.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low.
// Between acceptance and the result register, the scan reads one stored
// interval per cycle from the single-port slot memory, stopping early on an
// invalid interval or an overlap. One request is in work at a time; the next
// is accepted as soon as the previous result has been written to the output
// register, even if that result is still stalled.
// Reset empties the table at once through its fill count; no clearing pass.
// While the receiver stalls, the result item holds, and a finished request
// waits in the controller until the output register is free.

module interval_reservation_table #(
  parameter int MAX_EVENTS = 64,
  parameter int TIME_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  irt_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output irt_pkg::out_item_t out_item_o
);
  import irt_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencing of accept, scan and commit.
  irt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Table storage, compare and result register.
  irt_datapath #(
    .MAX_EVENTS (MAX_EVENTS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

// File: design/irt_datapath.sv
// Datapath of the interval reservation table: request registers, slot memory,
// scan counter, overlap compare, fill count and result register. Uses irt_pkg.

module irt_datapath #(
  parameter int MAX_EVENTS = 64,
  parameter int TIME_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  irt_pkg::in_item_t  in_item_i,
  input  logic               out_stall_i,
  input  irt_pkg::dp_cmd_t   cmd_i,
  output irt_pkg::dp_sts_t   sts_o,
  output logic               out_valid_o,
  output irt_pkg::out_item_t out_item_o
);
  import irt_pkg::*;

  localparam int IdxW = $clog2(MAX_EVENTS);
  localparam int CntW = $clog2(MAX_EVENTS + 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(MAX_EVENTS);
  localparam logic [CntW-1:0] OneCnt  = CntW'(1);

  logic [TIME_WIDTH-1:0]   s_w, e_w;
  logic [TIME_WIDTH-1:0]   req_s_q, req_e_q;
  logic [2*TIME_WIDTH-1:0] slot_q [MAX_EVENTS];
  logic [2*TIME_WIDTH-1:0] rdata_q;
  logic [TIME_WIDTH-1:0]   rd_s_w, rd_e_w;
  logic [CntW-1:0]         count_q, count_d;
  logic [CntW-1:0]         scan_idx_q, scan_idx_d;
  logic [CntW-1:0]         count_after_w;
  logic [CntW+ENTRIES_W-1:0] count_ext_w;
  logic                    pend_q, pend_d;
  logic                    hit_q, hit_d;
  logic                    invalid_q, invalid_d;
  logic                    out_valid_q, out_valid_d;
  out_item_t               out_item_q;
  logic                    more_w, issue_w, overlap_w, book_w;
  status_e                 status_w;

  // Fold the input times into the table's time width.
  if (TIME_WIDTH <= TIME_IN_W) begin : g_trunc
    assign s_w = in_item_i.start_time[TIME_WIDTH-1:0];
    assign e_w = in_item_i.end_time[TIME_WIDTH-1:0];
  end else begin : g_ext
    assign s_w = {{(TIME_WIDTH-TIME_IN_W){1'b0}}, in_item_i.start_time};
    assign e_w = {{(TIME_WIDTH-TIME_IN_W){1'b0}}, in_item_i.end_time};
  end

  // Scan control: one stored slot is read per cycle until the fill count.
  assign more_w    = scan_idx_q < count_q;
  assign issue_w   = cmd_i.scan && more_w && !hit_q && !invalid_q;
  assign rd_s_w    = rdata_q[2*TIME_WIDTH-1:TIME_WIDTH];
  assign rd_e_w    = rdata_q[TIME_WIDTH-1:0];
  assign overlap_w = (rd_s_w < req_e_q) && (rd_e_w > req_s_q);

  // Outcome of the request once the scan is over.
  always_comb begin
    if (invalid_q) begin
      status_w = ST_INVALID;
    end else if (hit_q) begin
      status_w = ST_OVERLAP;
    end else if (count_q == FullCnt) begin
      status_w = ST_FULL;
    end else begin
      status_w = ST_BOOKED;
    end
  end

  assign book_w        = cmd_i.commit && (status_w == ST_BOOKED);
  assign count_after_w = book_w ? count_q + OneCnt : count_q;
  assign count_ext_w   = {{ENTRIES_W{1'b0}}, count_after_w};

  // Next values of the control registers.
  always_comb begin
    count_d     = count_after_w;
    scan_idx_d  = scan_idx_q;
    pend_d      = issue_w;
    hit_d       = hit_q;
    invalid_d   = invalid_q;
    out_valid_d = out_valid_q;
    if (cmd_i.load) begin
      scan_idx_d = '0;
      pend_d     = 1'b0;
      hit_d      = 1'b0;
      invalid_d  = !(s_w < e_w);
    end else begin
      if (issue_w) begin
        scan_idx_d = scan_idx_q + OneCnt;
      end
      if (pend_q && overlap_w) begin
        hit_d = 1'b1;
      end
    end
    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      scan_idx_q  <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      invalid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      scan_idx_q  <= scan_idx_d;
      pend_q      <= pend_d;
      hit_q       <= hit_d;
      invalid_q   <= invalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_s_q <= s_w;
      req_e_q <= e_w;
    end
    if (cmd_i.commit) begin
      out_item_q.booked       <= book_w;
      out_item_q.status       <= status_w;
      out_item_q.entries_used <= count_ext_w[ENTRIES_W-1:0];
    end
  end

  // Slot memory: written at the fill count, read at the scan index.
  always_ff @(posedge clk_i) begin
    if (book_w) begin
      slot_q[count_q[IdxW-1:0]] <= {req_s_q, req_e_q};
    end
    if (issue_w) begin
      rdata_q <= slot_q[scan_idx_q[IdxW-1:0]];
    end
  end

  assign sts_o.done     = invalid_q || hit_q || (!more_w && !pend_q);
  assign sts_o.out_busy = out_valid_q && out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_item_o     = out_item_q;

endmodule

// File: design/irt_ctrl.sv
// Controller of the interval reservation table: accepts a request, runs the
// table scan and commits the result. Uses irt_pkg.

module irt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  irt_pkg::dp_sts_t sts_i,
  output irt_pkg::dp_cmd_t cmd_o
);
  import irt_pkg::*;

  ctrl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      CS_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = CS_SCAN;
        end
      end
      CS_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.done) begin
          state_d = CS_FINISH;
        end
      end
      CS_FINISH: begin
        // Wait until the result register can take the new item.
        if (!sts_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = CS_IDLE;
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

endmodule
